// File: hdl/utd_pkg.sv
`timescale 1ns / 1ps
// utd_pkg: shared types and constants of the text code unit decoder.
// No dependencies.

package utd_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);
  localparam int unsigned IdxW       = $clog2(MaxResults);

  localparam logic [31:0] ERR_CP = 32'hFFFF_FFFF;

  // Encoding mode codes; the reserved code decodes as UTF-32.
  localparam logic [1:0] MODE_UTF8     = 2'd0;
  localparam logic [1:0] MODE_UTF16    = 2'd1;
  localparam logic [1:0] MODE_UTF32    = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  // Configuration register indexes.
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_BASE = 1'b1;

  // Results produced by one code unit, in delivery order.
  typedef struct packed {
    logic [CntW-1:0]              count;
    logic [MaxResults-1:0][31:0]  cp;
    logic [MaxResults-1:0][31:0]  off;
  } utd_batch_t;

endpackage

// File: hdl/utd_decoder.sv
`timescale 1ns / 1ps
// utd_decoder: configuration registers, decode state and the single-pass
// decode of one code unit into a batch of results. Depends on utd_pkg.

module utd_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               step_i,
  input  logic [31:0]        unit_i,
  input  logic               last_i,
  output utd_pkg::utd_batch_t batch_o
);

  logic [1:0]  mode_q;
  logic [31:0] base_q;
  logic [20:0] pv_q, pv_d;
  logic [2:0]  need_q, need_d;
  logic [1:0]  rc_q, rc_d;
  logic        hs_vld_q, hs_vld_d;
  logic [9:0]  hs_q, hs_d;
  logic [31:0] seq_q, seq_d;
  logic [31:0] next_off_q;

  logic [7:0]  byte_w;
  logic [15:0] word_w;
  logic [2:0]  lead_len;
  logic [20:0] lead_val;
  logic [20:0] cont_pv;
  logic [1:0]  cont_rc;
  logic        emit_pv, flush_en, lead_en, plain_en;
  logic [1:0]  flush_rc;
  logic [2:0]  n;

  assign byte_w  = unit_i[7:0];
  assign word_w  = unit_i[15:0];
  assign cont_pv = {pv_q[14:0], byte_w[5:0]};
  assign cont_rc = rc_q + 2'd1;

  // Lead byte class: sequence length and payload bits.
  always_comb begin
    lead_len = 3'd0;
    lead_val = '0;
    if (byte_w[7:5] == 3'b110) begin
      lead_len = 3'd2;
      lead_val = {16'd0, byte_w[4:0]};
    end else if (byte_w[7:4] == 4'b1110) begin
      lead_len = 3'd3;
      lead_val = {17'd0, byte_w[3:0]};
    end else if (byte_w[7:3] == 5'b11110) begin
      lead_len = 3'd4;
      lead_val = {18'd0, byte_w[2:0]};
    end
  end

  always_comb begin
    batch_o  = '0;
    n        = '0;
    pv_d     = pv_q;
    need_d   = need_q;
    rc_d     = rc_q;
    hs_vld_d = hs_vld_q;
    hs_d     = hs_q;
    seq_d    = seq_q;
    emit_pv  = 1'b0;
    flush_en = 1'b0;
    flush_rc = rc_q;
    lead_en  = 1'b0;
    plain_en = 1'b0;

    case (mode_q)
      utd_pkg::MODE_UTF8: begin
        if (need_q == 3'd0) begin
          lead_en = 1'b1;
        end else if (byte_w[7:6] == 2'b10) begin
          if (({1'b0, cont_rc} + 3'd1) >= need_q) begin
            emit_pv = 1'b1;
          end else if (last_i) begin
            flush_en = 1'b1;
            flush_rc = cont_rc;
          end else begin
            pv_d = cont_pv;
            rc_d = cont_rc;
          end
        end else begin
          flush_en = 1'b1;
          lead_en  = 1'b1;
        end

        if (emit_pv || flush_en) begin
          pv_d   = '0;
          need_d = 3'd0;
          rc_d   = 2'd0;
        end

        if (emit_pv) begin
          batch_o.cp[n[1:0]]  = {11'd0, cont_pv};
          batch_o.off[n[1:0]] = seq_q;
          n = n + 3'd1;
        end

        // one error for the lead and for each continuation taken
        if (flush_en) begin
          for (int k = 0; k < 3; k++) begin
            if (2'(k) <= flush_rc) begin
              batch_o.cp[n[1:0]]  = utd_pkg::ERR_CP;
              batch_o.off[n[1:0]] = seq_q + 32'(k);
              n = n + 3'd1;
            end
          end
        end

        if (lead_en) begin
          if (!byte_w[7]) begin
            batch_o.cp[n[1:0]]  = {25'd0, byte_w[6:0]};
            batch_o.off[n[1:0]] = next_off_q;
            n = n + 3'd1;
          end else if (lead_len == 3'd0 || last_i) begin
            batch_o.cp[n[1:0]]  = utd_pkg::ERR_CP;
            batch_o.off[n[1:0]] = next_off_q;
            n = n + 3'd1;
          end else begin
            pv_d   = lead_val;
            need_d = lead_len;
            rc_d   = 2'd0;
            seq_d  = next_off_q;
          end
        end
      end

      utd_pkg::MODE_UTF16: begin
        if (hs_vld_q) begin
          hs_vld_d = 1'b0;
          if (word_w[15:10] == 6'b110111) begin
            batch_o.cp[n[1:0]]  = {12'd0, hs_q, word_w[9:0]} + 32'h0001_0000;
            batch_o.off[n[1:0]] = seq_q;
            n = n + 3'd1;
          end else begin
            batch_o.cp[n[1:0]]  = utd_pkg::ERR_CP;
            batch_o.off[n[1:0]] = seq_q;
            n = n + 3'd1;
            plain_en = 1'b1;
          end
        end else begin
          plain_en = 1'b1;
        end

        if (plain_en) begin
          if (word_w[15:10] == 6'b110110) begin
            if (last_i) begin
              batch_o.cp[n[1:0]]  = utd_pkg::ERR_CP;
              batch_o.off[n[1:0]] = next_off_q;
              n = n + 3'd1;
            end else begin
              hs_vld_d = 1'b1;
              hs_d     = word_w[9:0];
              seq_d    = next_off_q;
            end
          end else begin
            batch_o.cp[n[1:0]]  = {16'd0, word_w};
            batch_o.off[n[1:0]] = next_off_q;
            n = n + 3'd1;
          end
        end
      end

      default: begin
        batch_o.cp[0]  = unit_i;
        batch_o.off[0] = next_off_q;
        n = 3'd1;
      end
    endcase

    batch_o.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= utd_pkg::MODE_UTF8;
      base_q     <= '0;
      pv_q       <= '0;
      need_q     <= '0;
      rc_q       <= '0;
      hs_vld_q   <= 1'b0;
      hs_q       <= '0;
      seq_q      <= '0;
      next_off_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == utd_pkg::REG_MODE) begin
        mode_q   <= cfg_data_i[1:0];
        pv_q     <= '0;
        need_q   <= '0;
        rc_q     <= '0;
        hs_vld_q <= 1'b0;
      end else begin
        base_q     <= cfg_data_i;
        next_off_q <= cfg_data_i;
      end
    end else if (step_i) begin
      pv_q       <= pv_d;
      need_q     <= need_d;
      rc_q       <= rc_d;
      hs_vld_q   <= hs_vld_d;
      hs_q       <= hs_d;
      seq_q      <= seq_d;
      next_off_q <= last_i ? base_q : next_off_q + 32'd1;
    end
  end

  // open UTF-8 sequence always has room left for at least one more byte
  a_rc_below_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    need_q != 3'd0 |-> ({1'b0, rc_q} + 3'd1) < need_q)
    else $error("continuation count reached sequence length");

  a_need_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    need_q == 3'd0 || need_q == 3'd2 || need_q == 3'd3 || need_q == 3'd4)
    else $error("illegal open sequence length");

  a_hs_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hs_vld_q |-> mode_q == utd_pkg::MODE_UTF16)
    else $error("pending surrogate outside UTF-16 mode");

  a_no_mixed_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hs_vld_q && need_q != 3'd0))
    else $error("surrogate and UTF-8 sequence open together");

endmodule

// File: hdl/utd_result_buf.sv
`timescale 1ns / 1ps
// utd_result_buf: holds one decoded batch and hands its results out one
// request at a time. Depends on utd_pkg.

module utd_result_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  utd_pkg::utd_batch_t batch_i,
  output logic                can_load_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         code_point_o,
  output logic [31:0]         unit_offset_o,
  output logic                run_end_o
);

  utd_pkg::utd_batch_t           buf_q;
  logic [utd_pkg::CntW-1:0]      cnt_q;
  logic [utd_pkg::IdxW-1:0]      idx_q;
  logic                          fire, last_ent;

  assign out_valid_o   = cnt_q != '0;
  assign fire          = out_valid_o && out_ready_i;
  assign last_ent      = ({1'b0, idx_q} + utd_pkg::CntW'(1)) == cnt_q;
  assign can_load_o    = !out_valid_o || (fire && last_ent);
  assign code_point_o  = buf_q.cp[idx_q];
  assign unit_offset_o = buf_q.off[idx_q];
  assign run_end_o     = last_ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= batch_i.count;
      idx_q <= '0;
    end else if (fire) begin
      if (last_ent) begin
        cnt_q <= '0;
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + utd_pkg::IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= batch_i;
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> can_load_o)
    else $error("batch loaded over undelivered results");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= utd_pkg::CntW'(utd_pkg::MaxResults))
    else $error("result count out of range");

  a_idx_in_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, idx_q} < cnt_q)
    else $error("read index beyond batch");

endmodule

// File: hdl/unicode_text_unit_decoder.sv
`timescale 1ns / 1ps
// unicode_text_unit_decoder: top level; input register, decoder and result
// buffer. Depends on utd_pkg, utd_decoder and utd_result_buf.

// Decodes a stream of UTF-8 bytes, UTF-16 words or UTF-32 words (chosen by
// encoding_mode) into code points, each tagged with the unit offset of its
// first unit, counted from cluster_base, which reloads after every unit
// marked last_unit. Invalid input yields 0xFFFFFFFF and the decoder moves on
// one unit; run_end_o flags the final result caused by a unit, and a unit
// that only opens a sequence yields none. Flow: a request is registered in
// the input register, decoded in one pass into the result buffer, and its
// first result is offered from there once the buffer is loaded. The
// result buffer sets the rate: a unit giving k results (up to four) holds
// it until all k are taken, so units that give at most one result stream
// at one request per clock while the receiver does not stall, and the input
// register takes one more request while a finished result waits. Write the
// configuration only while the block is empty; a mode write drops any open
// sequence and a base write restarts the offsets at once.

module unicode_text_unit_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] code_unit_i,
  input  logic        last_unit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] code_point_o,
  output logic [31:0] unit_offset_o,
  output logic        run_end_o
);

  // input register
  logic        in_vld_q;
  logic [31:0] unit_q;
  logic        last_q;

  logic                step;
  logic                can_load;
  utd_pkg::utd_batch_t batch;

  // decode when a unit is held and the buffer will be free at this edge
  assign step       = in_vld_q && can_load;
  assign in_ready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      unit_q <= code_unit_i;
      last_q <= last_unit_i;
    end
  end

  utd_decoder u_decoder (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .unit_i     (unit_q),
    .last_i     (last_q),
    .batch_o    (batch)
  );

  utd_result_buf u_result_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (step),
    .batch_i       (batch),
    .can_load_o    (can_load),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_point_o  (code_point_o),
    .unit_offset_o (unit_offset_o),
    .run_end_o     (run_end_o)
  );

  // a held unit is never lost while the buffer is busy
  a_hold_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !step && !(in_valid_i && in_ready_o) |=> in_vld_q)
    else $error("held request dropped");

  // new request only lands in an empty or draining input register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_vld_q |-> step)
    else $error("input register overwritten");

  a_decode_batch_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> batch.count <= utd_pkg::CntW'(utd_pkg::MaxResults))
    else $error("decoded batch too large");

endmodule

// File: dv/utd_decode_checker.sv
`timescale 1ns / 1ps
// utd_decode_checker: watches the register, request and result ports of the
// text unit decoder, predicts the code points of each request and compares.
// Depends on utd_pkg.

module utd_decode_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] code_unit_i,
  input  logic        last_unit_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] code_point_i,
  input  logic [31:0] unit_offset_i,
  input  logic        run_end_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o,
  output int unsigned results_seen_o,
  output int unsigned errors_seen_o
);

  typedef struct packed {
    logic [31:0] cp;
    logic [31:0] off;
    logic        run_end;
  } cp_rec_t;

  cp_rec_t step_cps[$];
  cp_rec_t expected_cps[$];

  // Decoder state
  logic [1:0]  mode;
  logic [31:0] base;
  logic [20:0] acc;
  logic [2:0]  seq_len;
  logic [1:0]  cont_cnt;
  logic [15:0] hi_sur;
  logic [31:0] seq_off;
  logic [31:0] nxt_off;

  int unsigned n_fail;
  int unsigned n_res;
  int unsigned n_err;

  task automatic put_cp(input logic [31:0] cp, input logic [31:0] off);
    cp_rec_t r;
    if (step_cps.size() < utd_pkg::MaxResults) begin
      r.cp      = cp;
      r.off     = off;
      r.run_end = 1'b0;
      step_cps.push_back(r);
    end
  endtask

  task automatic drop_seq();
    acc      = '0;
    seq_len  = '0;
    cont_cnt = '0;
  endtask

  // One error for the lead byte and one per continuation taken so far.
  task automatic flush_seq_errors();
    int k;
    for (k = 0; k <= int'(cont_cnt); k++) put_cp(utd_pkg::ERR_CP, seq_off + 32'(k));
    drop_seq();
  endtask

  task automatic utf8_lead(input logic [7:0] b, input logic [31:0] off, input logic last);
    logic [2:0]  len;
    logic [20:0] lead_bits;
    if (!b[7]) begin
      put_cp({24'h0, b}, off);
    end else begin
      if (b[7:5] == 3'b110) begin
        len = 3'd2;
        lead_bits = {16'h0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        len = 3'd3;
        lead_bits = {17'h0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        len = 3'd4;
        lead_bits = {18'h0, b[2:0]};
      end else begin
        len = 3'd0;
        lead_bits = '0;
      end
      // continuation or 0xF8.. as lead, or a lead with nothing to follow
      if (len == 3'd0 || last) begin
        put_cp(utd_pkg::ERR_CP, off);
      end else begin
        acc      = lead_bits;
        seq_len  = len;
        cont_cnt = '0;
        seq_off  = off;
      end
    end
  endtask

  task automatic utf8_byte(input logic [7:0] b, input logic [31:0] off, input logic last);
    if (seq_len == 3'd0) begin
      utf8_lead(b, off, last);
    end else if (b[7:6] == 2'b10) begin
      acc      = {acc[14:0], b[5:0]};
      cont_cnt = cont_cnt + 2'd1;
      if ({1'b0, cont_cnt} + 3'd1 >= seq_len) begin
        put_cp({11'h0, acc}, seq_off);
        drop_seq();
      end else if (last) begin
        flush_seq_errors();
      end
    end else begin
      // broken sequence: error out what was taken, retry the byte as a lead
      flush_seq_errors();
      utf8_lead(b, off, last);
    end
  endtask

  task automatic utf16_plain(input logic [15:0] w, input logic [31:0] off, input logic last);
    if (w[15:10] == 6'b110110) begin
      if (last) begin
        put_cp(utd_pkg::ERR_CP, off);
      end else begin
        hi_sur  = w;
        seq_off = off;
      end
    end else begin
      put_cp({16'h0, w}, off);
    end
  endtask

  task automatic utf16_word(input logic [15:0] w, input logic [31:0] off, input logic last);
    if (hi_sur != 16'h0000 && w[15:10] == 6'b110111) begin
      // pair: ten bits from each half on top of the supplementary base
      put_cp(32'h0001_0000 + {12'h0, hi_sur[9:0], w[9:0]}, seq_off);
      hi_sur = '0;
    end else begin
      if (hi_sur != 16'h0000) begin
        put_cp(utd_pkg::ERR_CP, seq_off);
        hi_sur = '0;
      end
      utf16_plain(w, off, last);
    end
  endtask

  task automatic decode_unit(input logic [31:0] unit, input logic last);
    logic [31:0] off;
    cp_rec_t     r;
    int          i;
    off = nxt_off;
    step_cps.delete();
    case (mode)
      utd_pkg::MODE_UTF8:  utf8_byte(unit[7:0], off, last);
      utd_pkg::MODE_UTF16: utf16_word(unit[15:0], off, last);
      default:             put_cp(unit, off);
    endcase
    nxt_off = last ? base : off + 32'd1;
    for (i = 0; i < step_cps.size(); i++) begin
      r = step_cps[i];
      r.run_end = (i == step_cps.size() - 1);
      expected_cps.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cp_rec_t want;
    if (!rst_ni) begin
      mode    = utd_pkg::MODE_UTF8;
      base    = '0;
      drop_seq();
      hi_sur  = '0;
      seq_off = '0;
      nxt_off = '0;
      expected_cps.delete();
      n_fail  = 0;
      n_res   = 0;
      n_err   = 0;
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
      results_seen_o <= 0;
      errors_seen_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == utd_pkg::REG_MODE) begin
          mode = cfg_data_i[1:0];
          drop_seq();
          hi_sur = '0;
        end else if (cfg_idx_i == utd_pkg::REG_BASE) begin
          base    = cfg_data_i;
          nxt_off = cfg_data_i;
        end
      end

      if (in_valid_i && in_ready_i) decode_unit(code_unit_i, last_unit_i);

      if (out_valid_i && out_ready_i) begin
        n_res++;
        if (code_point_i == utd_pkg::ERR_CP) n_err++;
        if (expected_cps.size() == 0) begin
          if (n_fail < 10)
            $display("unexpected result: cp=%h off=%h end=%b",
                     code_point_i, unit_offset_i, run_end_i);
          n_fail++;
        end else begin
          want = expected_cps.pop_front();
          if (want.cp !== code_point_i || want.off !== unit_offset_i ||
              want.run_end !== run_end_i) begin
            if (n_fail < 10)
              $display("result %0d: expected cp=%h off=%h end=%b, got cp=%h off=%h end=%b",
                       n_res, want.cp, want.off, want.run_end,
                       code_point_i, unit_offset_i, run_end_i);
            n_fail++;
          end
        end
      end

      mismatch_cnt_o <= n_fail;
      pending_o      <= expected_cps.size();
      results_seen_o <= n_res;
      errors_seen_o  <= n_err;
    end
  end

endmodule

// File: dv/unicode_text_unit_decoder_test.sv
`timescale 1ns / 1ps
// unicode_text_unit_decoder_test: stimulus and verdict for the text unit
// decoder. Depends on utd_pkg, unicode_text_unit_decoder, utd_decode_checker.

module unicode_text_unit_decoder_test;

  // Far above the slowest legal run: ~330 requests at up to four results,
  // each under heavy receiver stalls, plus the drains around register writes.
  localparam int unsigned CycleLimit = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] code_unit = '0;
  logic        last_unit = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] code_point;
  logic [31:0] unit_offset;
  logic        run_end;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned errors_seen;

  // Idle odds in percent, changed per phase by the main sequence
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned n_requests = 0;
  int unsigned n_writes = 0;
  int unsigned cycles = 0;

  logic [31:0] text_units[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  unicode_text_unit_decoder uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .code_unit_i   (code_unit),
    .last_unit_i   (last_unit),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .code_point_o  (code_point),
    .unit_offset_o (unit_offset),
    .run_end_o     (run_end)
  );

  utd_decode_checker decode_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .code_unit_i    (code_unit),
    .last_unit_i    (last_unit),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .code_point_i   (code_point),
    .unit_offset_i  (unit_offset),
    .run_end_i      (run_end),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending),
    .results_seen_o (results_seen),
    .errors_seen_o  (errors_seen)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("unicode_text_unit_decoder: mismatch");
      $finish;
    end
  end

  // Receiver side: stall odds follow the current phase.
  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // Bits above the active unit width are ignored by the block; keep them
  // random so every input bit toggles.
  function automatic logic [31:0] with_spare_bits(input logic [31:0] v, input int width);
    logic [31:0] r;
    r = $urandom;
    return (r & ~((32'h1 << width) - 32'h1)) | v;
  endfunction

  // One request; an optional random gap in front, then hold until accepted.
  task automatic send_unit(input logic [31:0] unit, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid  <= 1'b1;
    code_unit <= unit;
    last_unit <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_requests++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    send_unit(with_spare_bits({24'h0, b}, 8), last);
  endtask

  task automatic send_word(input logic [15:0] w, input logic last);
    send_unit(with_spare_bits({16'h0, w}, 16), last);
  endtask

  // Sender pauses until every predicted result is back. The checker's count
  // is registered, hence the first edge; the tail covers a request that
  // only opened a sequence and is still inside the two-stage pipe.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_writes++;
  endtask

  // UTF-8 text: mostly whole sequences of random length and content, some
  // cut short, some stray bytes.
  task automatic add_utf8_piece();
    int          kind;
    int          len;
    int          keep;
    int          i;
    logic [31:0] cp;
    logic [7:0]  seq_bytes[0:3];
    kind = $urandom_range(99);
    len  = $urandom_range(1, 4);
    cp   = $urandom;
    case (len)
      1: seq_bytes[0] = {1'b0, cp[6:0]};
      2: begin
        seq_bytes[0] = {3'b110, cp[10:6]};
        seq_bytes[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq_bytes[0] = {4'b1110, cp[15:12]};
        seq_bytes[1] = {2'b10, cp[11:6]};
        seq_bytes[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq_bytes[0] = {5'b11110, cp[20:18]};
        seq_bytes[1] = {2'b10, cp[17:12]};
        seq_bytes[2] = {2'b10, cp[11:6]};
        seq_bytes[3] = {2'b10, cp[5:0]};
      end
    endcase
    if (kind < 75) keep = len;
    else if (kind < 90) keep = $urandom_range(1, len);
    else keep = 0;
    if (keep == 0) begin
      text_units.push_back(with_spare_bits($urandom_range(255), 8));
    end else begin
      for (i = 0; i < keep; i++)
        text_units.push_back(with_spare_bits({24'h0, seq_bytes[i]}, 8));
    end
  endtask

  // UTF-16 text: plain words, surrogate pairs, lone halves, noise.
  task automatic add_utf16_piece();
    int          kind;
    logic [31:0] r;
    logic [15:0] w;
    kind = $urandom_range(99);
    r    = $urandom;
    if (kind < 50) begin
      w = r[15:0];
      if (w[15:11] == 5'b11011) w[12] = 1'b0;
      text_units.push_back(with_spare_bits({16'h0, w}, 16));
    end else if (kind < 80) begin
      text_units.push_back(with_spare_bits({16'h0, 6'b110110, r[19:10]}, 16));
      text_units.push_back(with_spare_bits({16'h0, 6'b110111, r[9:0]}, 16));
    end else if (kind < 90) begin
      text_units.push_back(with_spare_bits({16'h0, 6'b110110, r[9:0]}, 16));
    end else if (kind < 95) begin
      text_units.push_back(with_spare_bits({16'h0, 6'b110111, r[9:0]}, 16));
    end else begin
      text_units.push_back(with_spare_bits({16'h0, r[15:0]}, 16));
    end
  endtask

  task automatic add_utf32_piece();
    int kind;
    kind = $urandom_range(9);
    case (kind)
      0:       text_units.push_back(32'h0000_0000);
      1:       text_units.push_back(32'hFFFF_FFFF);
      2:       text_units.push_back(32'h0010_FFFF);
      default: text_units.push_back($urandom);
    endcase
  endtask

  // One stretch of random text under a fresh mode and base. Item ends fall
  // at random, so the base write of the next stretch often lands mid-item.
  task automatic run_text_stretch();
    int          pick;
    logic [1:0]  mode_code;
    logic [31:0] r;
    logic [31:0] base_val;
    int          i;
    pick = $urandom_range(5);
    if (pick < 2) mode_code = utd_pkg::MODE_UTF8;
    else if (pick < 4) mode_code = utd_pkg::MODE_UTF16;
    else if (pick == 4) mode_code = utd_pkg::MODE_UTF32;
    else mode_code = utd_pkg::MODE_RESERVED;  // decodes as UTF-32
    r = $urandom;
    wait_idle();
    write_reg(utd_pkg::REG_MODE, {r[31:2], mode_code});
    case ($urandom_range(3))
      0:       base_val = 32'h0000_0000;
      1:       base_val = 32'hFFFF_FFFF - $urandom_range(6);
      default: base_val = $urandom;
    endcase
    write_reg(utd_pkg::REG_BASE, base_val);
    text_units.delete();
    while (text_units.size() < 18) begin
      case (mode_code)
        utd_pkg::MODE_UTF8:  add_utf8_piece();
        utd_pkg::MODE_UTF16: add_utf16_piece();
        default:             add_utf32_piece();
      endcase
    end
    for (i = 0; i < text_units.size(); i++)
      send_unit(text_units[i], $urandom_range(11) == 0);
  endtask

  initial begin : main
    int ph;
    int seg;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- Directed: UTF-8, base close to the top so offsets wrap ----
    write_reg(utd_pkg::REG_MODE, {30'h0, utd_pkg::MODE_UTF8});
    write_reg(utd_pkg::REG_BASE, 32'hFFFF_FFFD);
    send_byte(8'h41, 1'b0);
    send_byte(8'hFF, 1'b0);   // cannot lead
    send_byte(8'h80, 1'b0);   // continuation seen as a lead
    send_byte(8'hE2, 1'b0);   // three-byte sequence, complete
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF0, 1'b0);   // four-byte lead, two good continuations, then
    send_byte(8'h9F, 1'b0);   // a plain byte: three errors plus the byte
    send_byte(8'h98, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hC3, 1'b1);   // lead arriving as the last unit
    send_byte(8'hE2, 1'b0);   // sequence still open at the last unit
    send_byte(8'h82, 1'b1);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b1);
    send_byte(8'hE2, 1'b0);   // left open; the mode write below drops it
    wait_idle();

    // ---- Directed: UTF-16 ----
    write_reg(utd_pkg::REG_MODE, {30'h0, utd_pkg::MODE_UTF16});
    send_word(16'hD83D, 1'b0);  // proper pair
    send_word(16'hDE00, 1'b0);
    send_word(16'hD83D, 1'b0);  // high surrogate with no partner
    send_word(16'h0041, 1'b0);
    send_word(16'hDC00, 1'b0);  // lone low passes through
    send_word(16'hD800, 1'b1);  // high surrogate as the last unit
    send_word(16'hFFFF, 1'b1);
    wait_idle();

    // ---- Directed: UTF-32 and the reserved mode, all-ones base ----
    write_reg(utd_pkg::REG_MODE, {30'h0, utd_pkg::MODE_UTF32});
    write_reg(utd_pkg::REG_BASE, 32'h0000_0000);
    send_unit(32'hFFFF_FFFF, 1'b0);
    send_unit(32'h0000_0000, 1'b1);
    wait_idle();
    write_reg(utd_pkg::REG_MODE, 32'hFFFF_FFFF);
    write_reg(utd_pkg::REG_BASE, 32'hFFFF_FFFF);
    send_unit(32'h1234_5678, 1'b0);
    send_unit(32'h0000_0000, 1'b1);

    // ---- Random text over four idling phases ----
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 59;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 59;
        end
        default: begin
          send_idle_pct = 13;
          stall_pct     = 13;
        end
      endcase
      for (seg = 0; seg < 4; seg++) run_text_stretch();
    end

    wait_idle();
    repeat (8) @(posedge clk);

    $display("%0d code units sent in all three modes plus the reserved one, %0d register writes",
             n_requests, n_writes);
    $display("%0d code points checked, %0d of them error markers, under four idling mixes",
             results_seen, errors_seen);
    if (mismatches == 0) begin
      $display("unicode_text_unit_decoder: match");
    end else begin
      $display("unicode_text_unit_decoder: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/utd_pkg.sv
hdl/utd_decoder.sv
hdl/utd_result_buf.sv
hdl/unicode_text_unit_decoder.sv
dv/utd_decode_checker.sv
dv/unicode_text_unit_decoder_test.sv
